// ----- rtl/rbe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rbe_pkg;

    // Input item of the integrator
    typedef struct packed {
        logic               opcode;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] pos_in_x;
        logic signed [31:0] pos_in_y;
        logic               ground_value;
    } t_in;

    // Result item of the integrator
    typedef struct packed {
        logic signed [31:0] pos_out_x;
        logic signed [31:0] pos_out_y;
        logic signed [31:0] vel_out_x;
        logic signed [31:0] vel_out_y;
    } t_out;

    // Opcode of an input item
    localparam logic OP_STEP   = 1'b0;
    localparam logic OP_GROUND = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MASS           = 3'd0,
        CFG_FRICTION_COEF  = 3'd1,
        CFG_FRICTION_SCALE = 3'd2,
        CFG_SPEED_LIMIT    = 3'd3,
        CFG_GRAVITY_ACCEL  = 3'd4,
        CFG_FALL_LIMIT     = 3'd5,
        CFG_GRAVITY_ON     = 3'd6,
        CFG_FRAME_TIME     = 3'd7
    } t_cfg_idx;

    // Operand pair for the shared multiplier
    typedef enum logic [4:0] {
        M_NONE,
        M_MASS_DT,
        M_FX_MD,
        M_FY_MD,
        M_SCALE_MASS,
        M_COEF_SM,
        M_F0L_DT,
        M_F0H_DT,
        M_F_F,
        M_AX_AX,
        M_AY_AY,
        M_AX_F,
        M_AY_F,
        M_G_DT,
        M_SL_SL,
        M_AX_SL,
        M_AY_SL,
        M_WX_DT,
        M_WY_DT
    } t_msel;

    // Destination for the registered product or other datapath update
    typedef enum logic [4:0] {
        W_NONE,
        W_MD,
        W_VX,
        W_VY,
        W_SM,
        W_F0,
        W_FACC,
        W_F_FINAL,
        W_S_LOAD,
        W_S_ADD,
        W_FF,
        W_NUM,
        W_ZERO_V,
        W_FRIC_X,
        W_FRIC_Y,
        W_GRAV,
        W_LIM_AXIS,
        W_LIM_X,
        W_LIM_Y,
        W_COMMIT,
        W_PX,
        W_PY,
        W_GROUND
    } t_wsel;

    // Commands from controller to datapath
    typedef struct packed {
        logic  load;
        logic  out_load;
        t_msel msel;
        t_wsel wsel;
        logic  sqrt_start;
        logic  div_start;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic fric_en;
        logic grav_on;
        logic ground;
        logic s_zero;
        logic fric_zero;
        logic lim_over;
        logic sqrt_busy;
        logic div_busy;
        logic out_free;
    } t_stat;

    // Clamp a wide signed value to 32-bit signed
    function automatic logic signed [31:0] f_sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Magnitude of a 32-bit signed value, exact for the most negative code
    function automatic logic [31:0] f_abs32(input logic signed [31:0] v);
        logic [31:0] u;
        u = v;
        return v[31] ? (~u + 32'd1) : u;
    endfunction

    // Apply the sign of a reference to a magnitude
    function automatic logic [31:0] f_with_sign(input logic signed [31:0] ref_v,
                                                input logic [31:0] m);
        return ref_v[31] ? (~m + 32'd1) : m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rigid_body_2d_euler_step.sv -----
// A set-ground item updates the ground flag and loads its result; a frame step adds a square
// root and two divisions when friction is normalized and again when the speed magnitude limit
// is normalized, using the 32-step square root and the 64-step divider, while all products
// share one 33x33 multiplier. A held result stalls the block.
// Throughput: one item at a time; the next input transfer is taken in the cycle after the
// result is loaded. Reset: synchronous active low; velocity and ground flag clear,
// registers take defaults.
`timescale 1ns / 1ps
`default_nettype none

module rigid_body_2d_euler_step
    import rbe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wen,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [30:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    rbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    rbe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // One item in flight: no back-to-back input transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input transfer taken while an item is in flight");

    // Never overwrite a result that has not been transferred
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

    // Square root and divider never run together
    a_units_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.sqrt_busy && w_stat.div_busy))
        else $error("square root and divider busy at once");

    // Start a unit only when it is free
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.sqrt_start || w_cmd.div_start) |-> (!w_stat.sqrt_busy && !w_stat.div_busy))
        else $error("iterative unit started while busy");

endmodule

`default_nettype wire

// ----- rtl/rbe_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rbe_sqrt
    import rbe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_busy,
    output logic [31:0]      o_root
);

    localparam int unsigned STEPS = 32;
    localparam int unsigned CW    = $clog2(STEPS);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_x;
    logic [33:0]   r_rem;
    logic [31:0]   r_root;

    logic [35:0] w_rem2;
    logic [35:0] w_trial;
    logic        w_ge;

    // Bring down two radicand bits and try the next root bit
    assign w_rem2  = {r_rem, r_x[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_rem2 >= w_trial);

    // Advance one root bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_x    <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x <= {r_x[61:0], 2'b00};
            if (w_ge) begin
                r_rem  <= 34'(w_rem2 - w_trial);
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= w_rem2[33:0];
                r_root <= {r_root[30:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ----- rtl/rbe_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rbe_div
    import rbe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic [63:0]      o_quot
);

    localparam int unsigned STEPS = 64;
    localparam int unsigned CW    = $clog2(STEPS);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_q;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;

    logic [32:0] w_rem2;
    logic        w_ge;

    // Shift in the next dividend bit and compare against the divisor
    assign w_rem2 = {r_rem, r_q[63]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_rem2 - {1'b0, r_den}) : w_rem2[31:0];
            r_q   <= {r_q[62:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ----- rtl/rbe_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rbe_dp
    import rbe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wen,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [30:0] i_cfg_wdata,
    input  wire t_in         i_in_data,
    input  wire logic        i_out_ready,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    output logic             o_out_valid,
    output t_out             o_out_data
);

    // Configuration registers
    logic [15:0] r_mass;
    logic [23:0] r_coef;
    logic [15:0] r_scale;
    logic [30:0] r_sl;
    logic [30:0] r_g;
    logic [30:0] r_fl;
    logic        r_gon;
    logic [15:0] r_dt;

    // Latched item
    logic               r_gv;
    logic signed [31:0] r_fx;
    logic signed [31:0] r_fy;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;

    // Body state and working values
    logic signed [31:0] r_vel_x;
    logic signed [31:0] r_vel_y;
    logic               r_ground;
    logic signed [31:0] r_wx;
    logic signed [31:0] r_wy;
    logic [31:0]        r_md;
    logic [31:0]        r_sm;
    logic [39:0]        r_f;
    logic [35:0]        r_facc;
    logic [63:0]        r_s;
    logic [63:0]        r_ff;
    logic [63:0]        r_num;
    logic signed [65:0] r_prod;

    // Output register
    logic r_ovalid;
    t_out r_out;

    logic signed [32:0] m_a;
    logic signed [32:0] m_b;
    logic signed [65:0] m_p;
    logic [31:0]        w_ax;
    logic [31:0]        w_ay;
    logic signed [65:0] w_r24;
    logic signed [65:0] w_r16;
    logic [55:0]        w_fsum;
    logic [31:0]        w_root;
    logic [63:0]        w_quot;
    logic [31:0]        w_qx_f;
    logic [31:0]        w_qy_f;
    logic [31:0]        w_q_sl;
    logic [31:0]        w_wx_u;
    logic [31:0]        w_wy_u;
    logic               w_sqrt_busy;
    logic               w_div_busy;

    // Select multiplier operands
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.msel)
            M_MASS_DT:    begin m_a = {17'b0, r_mass};     m_b = {17'b0, r_dt};       end
            M_FX_MD:      begin m_a = {r_fx[31], r_fx};    m_b = {1'b0, r_md};        end
            M_FY_MD:      begin m_a = {r_fy[31], r_fy};    m_b = {1'b0, r_md};        end
            M_SCALE_MASS: begin m_a = {17'b0, r_scale};    m_b = {17'b0, r_mass};     end
            M_COEF_SM:    begin m_a = {9'b0, r_coef};      m_b = {1'b0, r_sm};        end
            M_F0L_DT:     begin m_a = {13'b0, r_f[19:0]};  m_b = {17'b0, r_dt};       end
            M_F0H_DT:     begin m_a = {13'b0, r_f[39:20]}; m_b = {17'b0, r_dt};       end
            M_F_F:        begin m_a = {1'b0, r_f[31:0]};   m_b = {1'b0, r_f[31:0]};   end
            M_AX_AX:      begin m_a = {1'b0, w_ax};        m_b = {1'b0, w_ax};        end
            M_AY_AY:      begin m_a = {1'b0, w_ay};        m_b = {1'b0, w_ay};        end
            M_AX_F:       begin m_a = {1'b0, w_ax};        m_b = {1'b0, r_f[31:0]};   end
            M_AY_F:       begin m_a = {1'b0, w_ay};        m_b = {1'b0, r_f[31:0]};   end
            M_G_DT:       begin m_a = {2'b0, r_g};         m_b = {17'b0, r_dt};       end
            M_SL_SL:      begin m_a = {2'b0, r_sl};        m_b = {2'b0, r_sl};        end
            M_AX_SL:      begin m_a = {1'b0, w_ax};        m_b = {2'b0, r_sl};        end
            M_AY_SL:      begin m_a = {1'b0, w_ay};        m_b = {2'b0, r_sl};        end
            M_WX_DT:      begin m_a = {r_wx[31], r_wx};    m_b = {17'b0, r_dt};       end
            M_WY_DT:      begin m_a = {r_wy[31], r_wy};    m_b = {17'b0, r_dt};       end
            default:      begin m_a = '0;                  m_b = '0;                  end
        endcase
    end

    assign m_p = m_a * m_b;

    // Derived values of the registered product and working velocity
    assign w_ax   = f_abs32(r_wx);
    assign w_ay   = f_abs32(r_wy);
    assign w_wx_u = r_wx;
    assign w_wy_u = r_wy;
    assign w_r24  = (r_prod + 66'sd8388608) >>> 24;
    assign w_r16  = (r_prod + 66'sd32768) >>> 16;
    assign w_fsum = {20'b0, r_facc} + {r_prod[35:0], 20'b0};
    assign w_qx_f = (w_quot > {32'b0, w_ax}) ? w_ax : w_quot[31:0];
    assign w_qy_f = (w_quot > {32'b0, w_ay}) ? w_ay : w_quot[31:0];
    assign w_q_sl = (w_quot > {33'b0, r_sl}) ? {1'b0, r_sl} : w_quot[31:0];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass  <= 16'd256;
            r_coef  <= 24'd102400;
            r_scale <= 16'd768;
            r_sl    <= 31'd256000;
            r_g     <= 31'd128000;
            r_fl    <= 31'd256000;
            r_gon   <= 1'b0;
            r_dt    <= 16'd1092;
        end else if (i_cfg_wen) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MASS:           r_mass  <= i_cfg_wdata[15:0];
                CFG_FRICTION_COEF:  r_coef  <= i_cfg_wdata[23:0];
                CFG_FRICTION_SCALE: r_scale <= i_cfg_wdata[15:0];
                CFG_SPEED_LIMIT:    r_sl    <= i_cfg_wdata;
                CFG_GRAVITY_ACCEL:  r_g     <= i_cfg_wdata;
                CFG_FALL_LIMIT:     r_fl    <= i_cfg_wdata;
                CFG_GRAVITY_ON:     r_gon   <= i_cfg_wdata[0];
                CFG_FRAME_TIME:     r_dt    <= i_cfg_wdata[15:0];
                default:            r_mass  <= r_mass;
            endcase
        end
    end

    // Hold body state across items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_x  <= '0;
            r_vel_y  <= '0;
            r_ground <= 1'b0;
        end else begin
            case (i_cmd.wsel)
                W_COMMIT: begin
                    r_vel_x <= r_wx;
                    r_vel_y <= r_wy;
                end
                W_GROUND: begin
                    r_ground <= r_gv;
                    if (r_gv && !r_vel_y[31] && (r_vel_y != 32'sd0)) begin
                        r_vel_y <= '0;
                    end
                end
                default: begin
                    r_vel_x <= r_vel_x;
                end
            endcase
        end
    end

    // Latch the item, register the product, update working values
    always_ff @(posedge i_clk) begin
        r_prod <= m_p;
        if (i_cmd.load) begin
            r_gv <= i_in_data.ground_value;
            r_fx <= i_in_data.force_x;
            r_fy <= i_in_data.force_y;
            r_px <= i_in_data.pos_in_x;
            r_py <= i_in_data.pos_in_y;
        end
        case (i_cmd.wsel)
            W_MD:      r_md   <= r_prod[31:0];
            W_VX:      r_wx   <= f_sat32(68'(r_vel_x) + 68'(w_r24));
            W_VY:      r_wy   <= f_sat32(68'(r_vel_y) + 68'(w_r24));
            W_SM:      r_sm   <= r_prod[31:0];
            W_F0:      r_f    <= r_prod[55:16];
            W_FACC:    r_facc <= r_prod[35:0];
            W_F_FINAL: r_f    <= w_fsum[55:16];
            W_S_LOAD:  r_s    <= r_prod[63:0];
            W_S_ADD:   r_s    <= r_s + r_prod[63:0];
            W_FF:      r_ff   <= r_prod[63:0];
            W_NUM:     r_num  <= r_prod[63:0] + {33'b0, w_root[31:1]};
            W_ZERO_V: begin
                r_wx <= '0;
                r_wy <= '0;
            end
            W_FRIC_X:  r_wx <= r_wx[31] ? (w_wx_u + w_qx_f) : (w_wx_u - w_qx_f);
            W_FRIC_Y:  r_wy <= r_wy[31] ? (w_wy_u + w_qy_f) : (w_wy_u - w_qy_f);
            W_GRAV:    r_wy <= f_sat32(68'(r_wy) + 68'(w_r16));
            W_LIM_AXIS: begin
                if (w_ax > {1'b0, r_sl}) begin
                    r_wx <= f_with_sign(r_wx, {1'b0, r_sl});
                end else if (w_ay > {1'b0, r_fl}) begin
                    r_wy <= f_with_sign(r_wy, {1'b0, r_fl});
                end
            end
            W_LIM_X:   r_wx <= f_with_sign(r_wx, w_q_sl);
            W_LIM_Y:   r_wy <= f_with_sign(r_wy, w_q_sl);
            W_PX:      r_px <= f_sat32(68'(r_px) + 68'(w_r16));
            W_PY:      r_py <= f_sat32(68'(r_py) + 68'(w_r16));
            default:   r_md <= r_md;
        endcase
    end

    // Hold the result until the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.pos_out_x <= r_px;
            r_out.pos_out_y <= r_py;
            r_out.vel_out_x <= r_vel_x;
            r_out.vel_out_y <= r_vel_y;
        end
    end

    // Shared square root and divider
    rbe_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_val   (r_s),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_root)
    );

    rbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (w_root),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Report status
    always_comb begin
        o_stat.fric_en   = !r_gon || r_ground;
        o_stat.grav_on   = r_gon;
        o_stat.ground    = r_ground;
        o_stat.s_zero    = (r_s == 64'd0);
        o_stat.fric_zero = (r_f[39:32] != 8'd0) || (r_s < r_ff);
        o_stat.lim_over  = (r_s > r_ff);
        o_stat.sqrt_busy = w_sqrt_busy;
        o_stat.div_busy  = w_div_busy;
        o_stat.out_free  = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- rtl/rbe_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rbe_ctrl
    import rbe_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_opcode,
    input  wire t_stat i_stat,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE, S_GND,
        S_MD, S_MDW, S_FX, S_FY, S_SM, S_SMW, S_CS, S_CSW,
        S_FL, S_FH, S_FW, S_AX2, S_AY2, S_FF, S_FFW, S_FDEC, S_FZ,
        S_FSQ, S_FSQW, S_FAX, S_FAXW, S_FDX, S_FDXW,
        S_FAPX, S_FAYW, S_FDY, S_FDYW, S_FAPY,
        S_GRAV, S_GRAVW,
        S_LIM, S_LAXIS, S_LAY2, S_LSL, S_LSLW, S_LDEC,
        S_LSQ, S_LSQW, S_LAX, S_LAXW, S_LDX, S_LDXW,
        S_LAPX, S_LAYW, S_LDY, S_LDYW, S_LAPY,
        S_PX, S_PY, S_PW, S_OUT
    } t_state;

    t_state r_state;

    // Sequence the step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= (i_opcode == OP_GROUND) ? S_GND : S_MD;
                    end
                end
                S_GND:   r_state <= S_OUT;
                S_MD:    r_state <= S_MDW;
                S_MDW:   r_state <= S_FX;
                S_FX:    r_state <= S_FY;
                S_FY:    r_state <= S_SM;
                S_SM:    r_state <= S_SMW;
                S_SMW:   r_state <= S_CS;
                S_CS:    r_state <= S_CSW;
                S_CSW:   r_state <= S_FL;
                S_FL:    r_state <= S_FH;
                S_FH:    r_state <= S_FW;
                S_FW:    r_state <= S_AX2;
                S_AX2:   r_state <= S_AY2;
                S_AY2:   r_state <= S_FF;
                S_FF:    r_state <= S_FFW;
                S_FFW:   r_state <= S_FDEC;
                S_FDEC: begin
                    if (!i_stat.fric_en || i_stat.s_zero) begin
                        r_state <= S_GRAV;
                    end else if (i_stat.fric_zero) begin
                        r_state <= S_FZ;
                    end else begin
                        r_state <= S_FSQ;
                    end
                end
                S_FZ:    r_state <= S_GRAV;
                S_FSQ:   r_state <= S_FSQW;
                S_FSQW:  if (!i_stat.sqrt_busy) r_state <= S_FAX;
                S_FAX:   r_state <= S_FAXW;
                S_FAXW:  r_state <= S_FDX;
                S_FDX:   r_state <= S_FDXW;
                S_FDXW:  if (!i_stat.div_busy) r_state <= S_FAPX;
                S_FAPX:  r_state <= S_FAYW;
                S_FAYW:  r_state <= S_FDY;
                S_FDY:   r_state <= S_FDYW;
                S_FDYW:  if (!i_stat.div_busy) r_state <= S_FAPY;
                S_FAPY:  r_state <= S_GRAV;
                S_GRAV: begin
                    r_state <= (i_stat.grav_on && !i_stat.ground) ? S_GRAVW : S_LIM;
                end
                S_GRAVW: r_state <= S_LIM;
                S_LIM:   r_state <= i_stat.grav_on ? S_LAXIS : S_LAY2;
                S_LAXIS: r_state <= S_PX;
                S_LAY2:  r_state <= S_LSL;
                S_LSL:   r_state <= S_LSLW;
                S_LSLW:  r_state <= S_LDEC;
                S_LDEC:  r_state <= i_stat.lim_over ? S_LSQ : S_PX;
                S_LSQ:   r_state <= S_LSQW;
                S_LSQW:  if (!i_stat.sqrt_busy) r_state <= S_LAX;
                S_LAX:   r_state <= S_LAXW;
                S_LAXW:  r_state <= S_LDX;
                S_LDX:   r_state <= S_LDXW;
                S_LDXW:  if (!i_stat.div_busy) r_state <= S_LAPX;
                S_LAPX:  r_state <= S_LAYW;
                S_LAYW:  r_state <= S_LDY;
                S_LDY:   r_state <= S_LDYW;
                S_LDYW:  if (!i_stat.div_busy) r_state <= S_LAPY;
                S_LAPY:  r_state <= S_PX;
                S_PX:    r_state <= S_PY;
                S_PY:    r_state <= S_PW;
                S_PW:    r_state <= S_OUT;
                S_OUT:   if (i_stat.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Decode datapath commands
    always_comb begin
        o_cmd.load       = (r_state == S_IDLE) && i_in_valid;
        o_cmd.out_load   = (r_state == S_OUT) && i_stat.out_free;
        o_cmd.sqrt_start = (r_state == S_FSQ) || (r_state == S_LSQ);
        o_cmd.div_start  = (r_state == S_FDX) || (r_state == S_FDY) ||
                           (r_state == S_LDX) || (r_state == S_LDY);
        o_cmd.msel       = M_NONE;
        o_cmd.wsel       = W_NONE;
        case (r_state)
            S_GND:   o_cmd.wsel = W_GROUND;
            S_MD:    o_cmd.msel = M_MASS_DT;
            S_MDW:   o_cmd.wsel = W_MD;
            S_FX:    o_cmd.msel = M_FX_MD;
            S_FY:    begin o_cmd.msel = M_FY_MD;      o_cmd.wsel = W_VX;      end
            S_SM:    begin o_cmd.msel = M_SCALE_MASS; o_cmd.wsel = W_VY;      end
            S_SMW:   o_cmd.wsel = W_SM;
            S_CS:    o_cmd.msel = M_COEF_SM;
            S_CSW:   o_cmd.wsel = W_F0;
            S_FL:    o_cmd.msel = M_F0L_DT;
            S_FH:    begin o_cmd.msel = M_F0H_DT;     o_cmd.wsel = W_FACC;    end
            S_FW:    o_cmd.wsel = W_F_FINAL;
            S_AX2:   o_cmd.msel = M_AX_AX;
            S_AY2:   begin o_cmd.msel = M_AY_AY;      o_cmd.wsel = W_S_LOAD;  end
            S_FF:    begin o_cmd.msel = M_F_F;        o_cmd.wsel = W_S_ADD;   end
            S_FFW:   o_cmd.wsel = W_FF;
            S_FZ:    o_cmd.wsel = W_ZERO_V;
            S_FAX:   o_cmd.msel = M_AX_F;
            S_FAXW:  o_cmd.wsel = W_NUM;
            S_FAPX:  begin o_cmd.msel = M_AY_F;       o_cmd.wsel = W_FRIC_X;  end
            S_FAYW:  o_cmd.wsel = W_NUM;
            S_FAPY:  o_cmd.wsel = W_FRIC_Y;
            S_GRAV:  o_cmd.msel = M_G_DT;
            S_GRAVW: o_cmd.wsel = W_GRAV;
            S_LIM:   o_cmd.msel = M_AX_AX;
            S_LAXIS: o_cmd.wsel = W_LIM_AXIS;
            S_LAY2:  begin o_cmd.msel = M_AY_AY;      o_cmd.wsel = W_S_LOAD;  end
            S_LSL:   begin o_cmd.msel = M_SL_SL;      o_cmd.wsel = W_S_ADD;   end
            S_LSLW:  o_cmd.wsel = W_FF;
            S_LAX:   o_cmd.msel = M_AX_SL;
            S_LAXW:  o_cmd.wsel = W_NUM;
            S_LAPX:  begin o_cmd.msel = M_AY_SL;      o_cmd.wsel = W_LIM_X;   end
            S_LAYW:  o_cmd.wsel = W_NUM;
            S_LAPY:  o_cmd.wsel = W_LIM_Y;
            S_PX:    begin o_cmd.msel = M_WX_DT;      o_cmd.wsel = W_COMMIT;  end
            S_PY:    begin o_cmd.msel = M_WY_DT;      o_cmd.wsel = W_PX;      end
            S_PW:    o_cmd.wsel = W_PY;
            default: begin o_cmd.msel = M_NONE;       o_cmd.wsel = W_NONE;    end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import rbe_pkg::*;

    localparam int  CYCLE_LIMIT = 4_000_000;
    localparam int  DRAIN_CYCLES = 400;
    localparam int  HOLD_CYCLES = 600;
    localparam int  IDLE_PCT = 18;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [30:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_data;

    rigid_body_2d_euler_step uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow registers and body state of the predictor
    longint body_mass, body_coef, body_fscale, body_slimit;
    longint body_grav, body_flimit, body_grav_on, body_dt;
    longint body_vx, body_vy;
    logic   body_grounded;

    t_out   expected_q[$];
    int     mismatches = 0;
    int     results_seen = 0;
    int     items_sent = 0;
    int     ground_items = 0;
    int     cycles = 0;
    bit     quiet = 1'b0;
    int     hold_req = 0;
    int     hold_seen = 0;
    int     hold_left = 0;

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_down_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint signed_as(input longint r, input longint unsigned m);
        return r < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned ratio_capped(input longint unsigned a,
                                                      input longint unsigned b,
                                                      input longint unsigned l,
                                                      input longint unsigned cap);
        longint unsigned q;
        q = (a * b + l / 2) / l;
        return q > cap ? cap : q;
    endfunction

    // Advance the body by one item and return the result it must produce
    function automatic t_out integrate(input t_in it);
        t_out r;
        longint px, py, vx, vy, fx, fy;
        longint unsigned ax, ay, s, f, l;
        px = longint'(it.pos_in_x);
        py = longint'(it.pos_in_y);
        if (it.opcode == OP_GROUND) begin
            body_grounded = it.ground_value;
            if (body_grounded && body_vy > 0) body_vy = 0;
        end else begin
            fx = longint'(it.force_x);
            fy = longint'(it.force_y);
            vx = sat_word(body_vx + round_down_shift(fx * body_mass * body_dt, 24));
            vy = sat_word(body_vy + round_down_shift(fy * body_mass * body_dt, 24));
            // friction against the direction of motion
            if (body_grav_on == 0 || body_grounded) begin
                ax = magnitude(vx);
                ay = magnitude(vy);
                s = ax * ax + ay * ay;
                if (s != 0) begin
                    f = longint'(body_coef * body_fscale * body_mass) >> 16;
                    f = (f * longint'(body_dt)) >> 16;
                    if (f >= 64'h1_0000_0000 || s < f * f) begin
                        vx = 0;
                        vy = 0;
                    end else begin
                        l = int_sqrt(s);
                        vx = vx - signed_as(vx, ratio_capped(ax, f, l, ax));
                        vy = vy - signed_as(vy, ratio_capped(ay, f, l, ay));
                    end
                end
            end
            if (body_grav_on != 0 && !body_grounded)
                vy = sat_word(vy + round_down_shift(body_grav * body_dt, 16));
            // speed limits
            ax = magnitude(vx);
            ay = magnitude(vy);
            if (body_grav_on != 0) begin
                if (ax > body_slimit) vx = signed_as(vx, body_slimit);
                else if (ay > body_flimit) vy = signed_as(vy, body_flimit);
            end else begin
                s = ax * ax + ay * ay;
                if (s > longint'(body_slimit * body_slimit)) begin
                    l = int_sqrt(s);
                    vx = signed_as(vx, ratio_capped(ax, body_slimit, l, body_slimit));
                    vy = signed_as(vy, ratio_capped(ay, body_slimit, l, body_slimit));
                end
            end
            body_vx = vx;
            body_vy = vy;
            px = sat_word(px + round_down_shift(vx * body_dt, 16));
            py = sat_word(py + round_down_shift(vy * body_dt, 16));
        end
        r.pos_out_x = px[31:0];
        r.pos_out_y = py[31:0];
        r.vel_out_x = body_vx[31:0];
        r.vel_out_y = body_vy[31:0];
        return r;
    endfunction

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_q.size());
            $display("** rigid_body_2d_euler_step: FAILED **");
            $finish;
        end
    end

    // Receiver: check each transfer out, then pick the next ready
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && out_valid && out_ready) begin
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result %h at cycle %0d", out_data, cycles);
            end else begin
                exp_r = expected_q.pop_front();
                if (out_data.pos_out_x !== exp_r.pos_out_x ||
                    out_data.pos_out_y !== exp_r.pos_out_y ||
                    out_data.vel_out_x !== exp_r.vel_out_x ||
                    out_data.vel_out_y !== exp_r.vel_out_y) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("mismatch at cycle %0d", cycles);
                        $display("  pos x exp %0d got %0d, pos y exp %0d got %0d",
                                 exp_r.pos_out_x, out_data.pos_out_x,
                                 exp_r.pos_out_y, out_data.pos_out_y);
                        $display("  vel x exp %0d got %0d, vel y exp %0d got %0d",
                                 exp_r.vel_out_x, out_data.vel_out_x,
                                 exp_r.vel_out_y, out_data.vel_out_y);
                    end
                end
            end
        end
        // hold off for a long stretch on request
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send_item(input t_in it);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        expected_q.push_back(integrate(it));
        items_sent++;
        if (it.opcode == OP_GROUND) ground_items++;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input longint val);
        cfg_wen <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val[30:0];
        case (idx)
            CFG_MASS:           body_mass = val & 64'hFFFF;
            CFG_FRICTION_COEF:  body_coef = val & 64'hFF_FFFF;
            CFG_FRICTION_SCALE: body_fscale = val & 64'hFFFF;
            CFG_SPEED_LIMIT:    body_slimit = val & 64'h7FFF_FFFF;
            CFG_GRAVITY_ACCEL:  body_grav = val & 64'h7FFF_FFFF;
            CFG_FALL_LIMIT:     body_flimit = val & 64'h7FFF_FFFF;
            CFG_GRAVITY_ON:     body_grav_on = val & 1;
            CFG_FRAME_TIME:     body_dt = val & 64'hFFFF;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_wen <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input longint m, input longint c, input longint sc,
                             input longint sl, input longint g, input longint fl,
                             input longint gon, input longint dt);
        drain();
        write_reg(CFG_MASS, m);
        write_reg(CFG_FRICTION_COEF, c);
        write_reg(CFG_FRICTION_SCALE, sc);
        write_reg(CFG_SPEED_LIMIT, sl);
        write_reg(CFG_GRAVITY_ACCEL, g);
        write_reg(CFG_FALL_LIMIT, fl);
        write_reg(CFG_GRAVITY_ON, gon);
        write_reg(CFG_FRAME_TIME, dt);
    endtask

    function automatic t_in make_item(input logic op, input longint fx, input longint fy,
                                      input longint px, input longint py, input logic gv);
        t_in it;
        it.opcode = op;
        it.force_x = fx[31:0];
        it.force_y = fy[31:0];
        it.pos_in_x = px[31:0];
        it.pos_in_y = py[31:0];
        it.ground_value = gv;
        return it;
    endfunction

    // Mostly moderate values so velocity stays inside the limits, some extremes
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(9))
            0, 1: w = $urandom;
            2: w = 32'h0;
            3: w = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: begin
                w = $urandom_range(0, 1 << 22);
                if ($urandom_range(1)) w = ~w + 32'd1;
            end
        endcase
        return w;
    endfunction

    function automatic longint pick(input longint lo_v, input longint hi_v,
                                    input longint dflt, input longint rnd);
        case ($urandom_range(5))
            0: return lo_v;
            1: return hi_v;
            2: return dflt;
            default: return rnd;
        endcase
    endfunction

    task automatic test_defaults();
        // reset values: slide with friction, gravity off
        send_item(make_item(OP_STEP, 0, 0, 0, 0, 1'b0));
        send_item(make_item(OP_STEP, 64'sd100000, -64'sd50000, 1000, -1000, 1'b1));
        send_item(make_item(OP_STEP, 64'sd20000000, 64'sd20000000, 0, 0, 1'b0));
        send_item(make_item(OP_STEP, 64'sd10, 0, 0, 0, 1'b0));
        send_item(make_item(OP_STEP, 64'sh7FFF_FFFF, -64'sh8000_0000,
                            64'sh7FFF_FFFF, -64'sh8000_0000, 1'b0));
        send_item(make_item(OP_STEP, -64'sh8000_0000, 64'sh7FFF_FFFF,
                            -64'sh8000_0000, 64'sh7FFF_FFFF, 1'b1));
        drain();
    endtask

    task automatic test_gravity_and_ground();
        write_all(256, 102400, 768, 256000, 128000, 256000, 1, 1092);
        // airborne fall, then per-axis limits on x first, else y
        send_item(make_item(OP_STEP, 0, 0, 500, 500, 1'b0));
        send_item(make_item(OP_STEP, 64'sd90000000, 0, 0, 0, 1'b0));
        send_item(make_item(OP_STEP, -64'sd90000000, 64'sd90000000, 0, 0, 1'b0));
        send_item(make_item(OP_STEP, 0, 64'sd99000000, 0, 0, 1'b0));
        // landing clears y velocity in the direction of gravity, force fields ignored
        send_item(make_item(OP_GROUND, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 77, -77, 1'b1));
        send_item(make_item(OP_STEP, 64'sd3000000, 0, 0, 0, 1'b0));
        send_item(make_item(OP_GROUND, -1, -1, 64'sh7FFF_FFFF, -64'sh8000_0000, 1'b0));
        send_item(make_item(OP_STEP, 0, -64'sd30000000, 0, 0, 1'b1));
        send_item(make_item(OP_GROUND, 0, 0, 0, 0, 1'b1));
        drain();
    endtask

    task automatic test_extremes();
        write_all(65535, 0, 65535, 0, 64'h7FFF_FFFF, 0, 0, 65535);
        send_item(make_item(OP_STEP, 64'sh7FFF_FFFF, 64'sd1, 0, 0, 1'b0));
        send_item(make_item(OP_STEP, -64'sh8000_0000, -64'sh8000_0000, 0, 0, 1'b0));
        write_all(65535, 64'hFF_FFFF, 65535, 64'h7FFF_FFFF, 64'h7FFF_FFFF,
                  64'h7FFF_FFFF, 0, 65535);
        send_item(make_item(OP_STEP, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 0, 0, 1'b0));
        write_all(0, 64'hFF_FFFF, 0, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 1, 0);
        send_item(make_item(OP_STEP, 64'sh7FFF_FFFF, -64'sh8000_0000,
                            64'sh7FFF_FFFF, -64'sh8000_0000, 1'b0));
        send_item(make_item(OP_STEP, 0, 0, 0, 0, 1'b0));
        drain();
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        t_in it;
        longint gon;
        for (int p = 0; p < phases; p++) begin
            gon = $urandom_range(1);
            write_all(pick(0, 65535, 256, $urandom_range(64, 1024)),
                      pick(0, 64'hFF_FFFF, 102400, $urandom_range(0, 1 << 18)),
                      pick(0, 65535, 768, $urandom_range(0, 2048)),
                      pick(0, 64'h7FFF_FFFF, 256000, $urandom_range(1, 1 << 22)),
                      pick(0, 64'h7FFF_FFFF, 128000, $urandom_range(0, 1 << 20)),
                      pick(0, 64'h7FFF_FFFF, 256000, $urandom_range(1, 1 << 22)),
                      gon, pick(0, 65535, 1092, $urandom_range(0, 8192)));
            quiet = (p == 1);
            for (int n = 0; n < per_phase; n++) begin
                it.opcode = ($urandom_range(99) < 15) ? OP_GROUND : OP_STEP;
                it.force_x = rand_word();
                it.force_y = rand_word();
                it.pos_in_x = $urandom_range(3) == 0 ? $urandom : rand_word();
                it.pos_in_y = $urandom_range(3) == 0 ? $urandom : rand_word();
                it.ground_value = 1'($urandom_range(1));
                send_item(it);
            end
            quiet = 1'b0;
        end
        drain();
    endtask

    task automatic test_backpressure();
        t_in it;
        // receiver holds off for a full pause while items keep coming, then mixed items
        hold_req = hold_req + 1;
        quiet = 1'b1;
        for (int n = 0; n < 20; n++) begin
            it = make_item(OP_STEP, rand_word(), rand_word(), $urandom, $urandom, 1'b0);
            send_item(it);
        end
        quiet = 1'b0;
        drain();
        for (int n = 0; n < 10; n++) begin
            it = make_item(1'($urandom_range(1)), rand_word(), rand_word(), $urandom,
                           $urandom, 1'($urandom_range(1)));
            send_item(it);
        end
        drain();
    endtask

    initial begin
        body_mass = 256;
        body_coef = 102400;
        body_fscale = 768;
        body_slimit = 256000;
        body_grav = 128000;
        body_flimit = 256000;
        body_grav_on = 0;
        body_dt = 1092;
        body_vx = 0;
        body_vy = 0;
        body_grounded = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_gravity_and_ground();
        test_extremes();
        test_backpressure();
        test_random_phases(8, 210);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d items (%0d set-ground), %0d results checked, %0d mismatches",
                 items_sent, ground_items, results_seen, mismatches);
        $display("settings swept: extremes of every register, gravity on and off, stalls");
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("** rigid_body_2d_euler_step: PASSED **");
        end else begin
            $display("** rigid_body_2d_euler_step: FAILED **");
        end
        $finish;
    end

endmodule
